/* design/first_fit_block_allocator_core_macros.svh */
// Assertion macros for the first-fit block allocator core.
// Included by the top level; needs nothing else.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ffba_pkg.sv */
// Shared constants, types and codes of the first-fit block allocator.
// No dependencies.
`default_nettype none

package ffba_pkg;

	localparam int NUM_BLOCKS   = 1024;
	localparam int BLOCK_BYTES  = 64;
	localparam int HEADER_BYTES = 16;

	localparam int IDX_W   = $clog2(NUM_BLOCKS + 1);
	localparam int ADDR_W  = $clog2(NUM_BLOCKS);
	localparam int BLK_SH  = $clog2(BLOCK_BYTES);
	localparam int OFF_W   = 16;
	localparam int BYTE_W  = 17;
	localparam int REQ_W   = 17;
	localparam int LG_W    = 4;
	localparam int ALIGN_W = 16;
	localparam int TOT_W   = 19;
	localparam int NEED_W  = TOT_W - BLK_SH;
	localparam int ST_W    = 2;

	localparam logic [IDX_W-1:0] NONE_IDX    = IDX_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0] FRONT_LIMIT = IDX_W'(NUM_BLOCKS / 4);

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_FIT = 2'd1;
	localparam logic [ST_W-1:0] ST_IGNORE = 2'd2;

	// One metadata word per block.
	typedef struct packed {
		logic             head;
		logic             used;
		logic [IDX_W-1:0] prev;
		logic [IDX_W-1:0] next;
		logic [IDX_W-1:0] back_len;
		logic [IDX_W-1:0] len;
	} entry_t;

endpackage

`default_nettype wire

/* design/first_fit_block_allocator_core.sv */
// First-fit block allocator core: free-list walk, split and coalesce sequencer
// over one metadata memory. Depends on ffba_pkg and the macros header.
//
// The pool holds NUM_BLOCKS blocks of BLOCK_BYTES bytes; every run carries its
// metadata (length, length of the run before it, free-list links, used and
// run-start flags) in one word of a single-port synchronous RAM. One request
// is handled at a time. After reset the block sweeps the RAM once, with
// s_tready low. After the transfer in, an allocate takes a walk step, a RAM
// read and a fit check per free-list entry visited, then read-modify-write
// steps to unlink and mark the run and split off a trailing remainder; when
// alignment needs it, a leading alignment run is first split off the same way.
// A valid free runs its checks, merges and relinking; an ignored free finishes
// after its checks. The steps are built on RAM accesses, so the single RAM port
// sets the pace. One result per request; a finished result waits in the output
// register while the next request is taken. Status 0 done, 1 no fit, 2 free
// ignored.
`default_nettype none

`include "first_fit_block_allocator_core_macros.svh"

module first_fit_block_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata: request_bytes[16:0], align_log2[20:17], free_offset[36:21], zero pad
	input  wire logic [39:0] s_tdata,
	// s_tuser: kind (0 allocate, 1 free)
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata: granted_offset[15:0], used_bytes[32:16], peak_bytes[49:33], zero pad
	output logic [55:0]      m_tdata,
	// m_tuser: status
	output logic [1:0]       m_tuser
);

	localparam int IW = ffba_pkg::IDX_W;
	localparam int AW = ffba_pkg::ADDR_W;
	localparam int BW = ffba_pkg::BYTE_W;

	typedef enum logic [5:0] {
		CLR, IDLE, DONE,
		P_RD, P_RMW_A, P_RMW_B,
		M_PL0, M_PL1,
		M_LR0, M_LR1, M_LR2, M_LR3,
		M_LI0, M_LI1, M_LI2, M_LI3,
		A_W0, A_W1, A_S1, A_S2, A_S3, A_S4,
		A_M0, A_M1, A_M2, A_M3, A_M4, A_M5, A_FIN,
		F0, F1, F2, F2B, F2C, F2D, F4, F5, F6, F6B, F7, F8, F9
	} state_t;

	// Field masks for read-modify-write steps.
	localparam ffba_pkg::entry_t MK_LEN      = '{len: '1, default: '0};
	localparam ffba_pkg::entry_t MK_BACK_LEN = '{back_len: '1, default: '0};
	localparam ffba_pkg::entry_t MK_NEXT     = '{next: '1, default: '0};
	localparam ffba_pkg::entry_t MK_PREV     = '{prev: '1, default: '0};
	localparam ffba_pkg::entry_t MK_LINKS    = '{next: '1, prev: '1, default: '0};
	localparam ffba_pkg::entry_t MK_FLAGS    = '{head: 1'b1, used: 1'b1, default: '0};
	localparam ffba_pkg::entry_t MK_FRESH    =
		'{head: 1'b1, used: 1'b1, next: '1, prev: '1, default: '0};
	localparam ffba_pkg::entry_t MK_USED     = '{used: 1'b1, default: '0};
	localparam ffba_pkg::entry_t MK_HEAD     = '{head: 1'b1, default: '0};

	function automatic ffba_pkg::entry_t ent(input logic hd, input logic us,
		input logic [IW-1:0] pv, input logic [IW-1:0] nx,
		input logic [IW-1:0] bf, input logic [IW-1:0] ln);
		ffba_pkg::entry_t e;
		e.head = hd; e.used = us; e.prev = pv; e.next = nx; e.back_len = bf; e.len = ln;
		return e;
	endfunction

	state_t              state_q, pret_q, mret_q;
	ffba_pkg::entry_t    mem [ffba_pkg::NUM_BLOCKS];
	ffba_pkg::entry_t    rd_q;
	ffba_pkg::entry_t    op_mask_q, op_val_q;
	logic [AW-1:0]       op_addr_q, clr_cnt_q;

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_addr;
	ffba_pkg::entry_t    mem_wdata;

	// Request fields.
	logic [ffba_pkg::REQ_W-1:0] req_q;
	logic [ffba_pkg::LG_W-1:0]  lg_q;
	logic [ffba_pkg::OFF_W-1:0] off_q;

	// Working registers.
	logic [IW-1:0]       list_head_q, list_tail_q;
	logic [IW-1:0]       idx_q, aux_q, visits_q, len_q, avail_q, skip_q, need_main_q;
	logic [IW-1:0]       m_idx_q, m_len_q, lr_nx_q, lr_pv_q;
	logic [ffba_pkg::NEED_W-1:0]  need_q;
	logic [ffba_pkg::ALIGN_W-1:0] diff_q;
	logic [ffba_pkg::OFF_W-1:0]   gr_q;
	logic [BW-1:0]       used_q, peak_q;
	logic [ffba_pkg::OFF_W-1:0]   res_gr_q, out_gr_q;
	logic [ffba_pkg::ST_W-1:0]    res_st_q, out_st_q;
	logic [BW-1:0]       out_used_q, out_peak_q;

	// Walk arithmetic for the entry at idx_q.
	logic [BW-1:0]                w_start, w_neg, used_add;
	logic [ffba_pkg::ALIGN_W-1:0] w_amask, w_diff;
	logic [ffba_pkg::TOT_W-1:0]   w_tot;
	logic [IW:0]                  pl_end, f_nx;
	logic [IW-1:0]                f_idx;

	always_comb begin
		w_start  = {idx_q, {ffba_pkg::BLK_SH{1'b0}}} + BW'(ffba_pkg::HEADER_BYTES);
		w_neg    = -w_start;
		w_amask  = (ffba_pkg::ALIGN_W'(1) << lg_q) - ffba_pkg::ALIGN_W'(1);
		w_diff   = w_neg[ffba_pkg::ALIGN_W-1:0] & w_amask;
		w_tot    = ffba_pkg::TOT_W'(req_q) + ffba_pkg::TOT_W'(w_diff)
			+ ffba_pkg::TOT_W'(ffba_pkg::HEADER_BYTES + ffba_pkg::BLOCK_BYTES - 1);
		used_add = used_q + {need_main_q, {ffba_pkg::BLK_SH{1'b0}}};
		pl_end   = {1'b0, m_idx_q} + {1'b0, m_len_q};
		f_nx     = {1'b0, idx_q} + {1'b0, len_q};
		f_idx    = IW'(off_q >> ffba_pkg::BLK_SH)
			- IW'(off_q[ffba_pkg::BLK_SH-1:0] == '0);
	end

	// RAM port control: the sweep, reads, and merged write-back.
	always_comb begin
		mem_re    = (state_q == P_RD) || (state_q == P_RMW_A);
		mem_we    = (state_q == P_RMW_B) || (state_q == CLR);
		mem_addr  = (state_q == CLR) ? clr_cnt_q : op_addr_q;
		mem_wdata = (rd_q & ~op_mask_q) | (op_val_q & op_mask_q);
		if (state_q == CLR) begin
			mem_wdata = '0;
			if (clr_cnt_q == '0) begin
				mem_wdata = ent(1'b1, 1'b0, ffba_pkg::NONE_IDX, ffba_pkg::NONE_IDX, '0,
					IW'(ffba_pkg::NUM_BLOCKS));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tdata  = {6'b0, out_peak_q, out_used_q, out_gr_q};
	assign m_tuser  = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLR;
			pret_q      <= IDLE;
			mret_q      <= IDLE;
			clr_cnt_q   <= '0;
			list_head_q <= '0;
			list_tail_q <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			// Drop the result after its transfer, unless a new one is loaded now.
			if (m_tvalid && m_tready && state_q != DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(ffba_pkg::NUM_BLOCKS - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						req_q    <= s_tdata[16:0];
						lg_q     <= s_tdata[20:17];
						off_q    <= s_tdata[36:21];
						res_gr_q <= '0;
						idx_q    <= list_head_q;
						visits_q <= '0;
						state_q  <= s_tuser ? F0 : A_W0;
					end
				end
				DONE: begin
					// Hold the result until the output register is free.
					if (!m_tvalid || m_tready) begin
						out_gr_q   <= res_gr_q;
						out_st_q   <= res_st_q;
						out_used_q <= used_q;
						out_peak_q <= peak_q;
						m_tvalid   <= 1'b1;
						state_q    <= IDLE;
					end
				end
				// RAM primitives: read, then optional merged write-back.
				P_RD: state_q <= pret_q;
				P_RMW_A: state_q <= P_RMW_B;
				P_RMW_B: state_q <= pret_q;
				// Set run length, mirror it into the following run's header.
				M_PL0: begin
					op_addr_q <= m_idx_q[AW-1:0];
					op_mask_q <= MK_LEN;
					op_val_q  <= ent(1'b0, 1'b0, '0, '0, '0, m_len_q);
					pret_q    <= M_PL1;
					state_q   <= P_RMW_A;
				end
				M_PL1: begin
					if (pl_end < (IW + 1)'(ffba_pkg::NUM_BLOCKS)) begin
						op_addr_q <= pl_end[AW-1:0];
						op_mask_q <= MK_BACK_LEN;
						op_val_q  <= ent(1'b0, 1'b0, '0, '0, m_len_q, '0);
						pret_q    <= mret_q;
						state_q   <= P_RMW_A;
					end else begin
						state_q <= mret_q;
					end
				end
				// Unlink m_idx_q from the free list.
				M_LR0: begin
					op_addr_q <= m_idx_q[AW-1:0];
					pret_q    <= M_LR1;
					state_q   <= P_RD;
				end
				M_LR1: begin
					lr_nx_q <= rd_q.next;
					lr_pv_q <= rd_q.prev;
					if (rd_q.next < ffba_pkg::NONE_IDX) begin
						op_addr_q <= rd_q.next[AW-1:0];
						op_mask_q <= MK_PREV;
						op_val_q  <= ent(1'b0, 1'b0, rd_q.prev, '0, '0, '0);
						pret_q    <= M_LR2;
						state_q   <= P_RMW_A;
					end else begin
						state_q <= M_LR2;
					end
				end
				M_LR2: begin
					if (lr_pv_q < ffba_pkg::NONE_IDX) begin
						op_addr_q <= lr_pv_q[AW-1:0];
						op_mask_q <= MK_NEXT;
						op_val_q  <= ent(1'b0, 1'b0, '0, lr_nx_q, '0, '0);
						pret_q    <= M_LR3;
						state_q   <= P_RMW_A;
					end else begin
						state_q <= M_LR3;
					end
				end
				M_LR3: begin
					if (list_head_q == m_idx_q) begin
						list_head_q <= lr_nx_q;
					end
					if (list_tail_q == m_idx_q) begin
						list_tail_q <= lr_pv_q;
					end
					op_addr_q <= m_idx_q[AW-1:0];
					op_mask_q <= MK_LINKS;
					op_val_q  <= ent(1'b0, 1'b0, ffba_pkg::NONE_IDX, ffba_pkg::NONE_IDX, '0, '0);
					pret_q    <= mret_q;
					state_q   <= P_RMW_A;
				end
				// Link m_idx_q: large runs at the front, others at the back.
				M_LI0: begin
					op_addr_q <= m_idx_q[AW-1:0];
					pret_q    <= M_LI1;
					state_q   <= P_RD;
				end
				M_LI1: begin
					op_addr_q <= m_idx_q[AW-1:0];
					op_mask_q <= MK_LINKS;
					op_val_q  <= ent(1'b0, 1'b0, ffba_pkg::NONE_IDX, ffba_pkg::NONE_IDX, '0, '0);
					pret_q    <= mret_q;
					state_q   <= P_RMW_A;
					if (list_head_q >= ffba_pkg::NONE_IDX || list_tail_q >= ffba_pkg::NONE_IDX) begin
						list_head_q <= m_idx_q;
						list_tail_q <= m_idx_q;
					end else if (rd_q.len > ffba_pkg::FRONT_LIMIT) begin
						op_addr_q <= list_head_q[AW-1:0];
						op_mask_q <= MK_PREV;
						op_val_q  <= ent(1'b0, 1'b0, m_idx_q, '0, '0, '0);
						pret_q    <= M_LI2;
					end else begin
						op_addr_q <= list_tail_q[AW-1:0];
						op_mask_q <= MK_NEXT;
						op_val_q  <= ent(1'b0, 1'b0, '0, m_idx_q, '0, '0);
						pret_q    <= M_LI3;
					end
				end
				M_LI2: begin
					op_addr_q   <= m_idx_q[AW-1:0];
					op_mask_q   <= MK_LINKS;
					op_val_q    <= ent(1'b0, 1'b0, ffba_pkg::NONE_IDX, list_head_q, '0, '0);
					list_head_q <= m_idx_q;
					pret_q      <= mret_q;
					state_q     <= P_RMW_A;
				end
				M_LI3: begin
					op_addr_q   <= m_idx_q[AW-1:0];
					op_mask_q   <= MK_LINKS;
					op_val_q    <= ent(1'b0, 1'b0, list_tail_q, ffba_pkg::NONE_IDX, '0, '0);
					list_tail_q <= m_idx_q;
					pret_q      <= mret_q;
					state_q     <= P_RMW_A;
				end
				// Allocate: walk the free list, one entry per read.
				A_W0: begin
					if (idx_q < ffba_pkg::NONE_IDX && visits_q < IW'(ffba_pkg::NUM_BLOCKS)) begin
						diff_q    <= w_diff;
						need_q    <= w_tot[ffba_pkg::TOT_W-1:ffba_pkg::BLK_SH];
						gr_q      <= ffba_pkg::OFF_W'(w_start + BW'(w_diff));
						op_addr_q <= idx_q[AW-1:0];
						pret_q    <= A_W1;
						state_q   <= P_RD;
					end else begin
						res_st_q <= ffba_pkg::ST_NO_FIT;
						state_q  <= DONE;
					end
				end
				A_W1: begin
					visits_q <= visits_q + IW'(1);
					if (ffba_pkg::NEED_W'(rd_q.len) < need_q) begin
						idx_q   <= rd_q.next;
						state_q <= A_W0;
					end else begin
						skip_q      <= IW'(diff_q >> ffba_pkg::BLK_SH);
						need_main_q <= IW'(need_q - ffba_pkg::NEED_W'(diff_q >> ffba_pkg::BLK_SH));
						len_q       <= rd_q.len;
						avail_q     <= rd_q.len;
						if ((diff_q >> ffba_pkg::BLK_SH) != '0) begin
							// Split off the leading padding run.
							m_idx_q <= idx_q;
							m_len_q <= IW'(diff_q >> ffba_pkg::BLK_SH);
							mret_q  <= A_S1;
							state_q <= M_PL0;
						end else begin
							state_q <= A_M0;
						end
					end
				end
				A_S1: begin
					m_idx_q <= idx_q;
					mret_q  <= A_S2;
					state_q <= M_LR0;
				end
				A_S2: begin
					m_idx_q <= idx_q;
					mret_q  <= A_S3;
					state_q <= M_LI0;
				end
				A_S3: begin
					idx_q     <= idx_q + skip_q;
					avail_q   <= len_q - skip_q;
					op_addr_q <= AW'(idx_q + skip_q);
					op_mask_q <= MK_FRESH;
					op_val_q  <= ent(1'b1, 1'b0, ffba_pkg::NONE_IDX, ffba_pkg::NONE_IDX, '0, '0);
					pret_q    <= A_S4;
					state_q   <= P_RMW_A;
				end
				A_S4: begin
					m_idx_q <= idx_q;
					m_len_q <= avail_q;
					mret_q  <= A_M0;
					state_q <= M_PL0;
				end
				A_M0: begin
					m_idx_q <= idx_q;
					mret_q  <= A_M1;
					state_q <= M_LR0;
				end
				A_M1: begin
					op_addr_q <= idx_q[AW-1:0];
					op_mask_q <= MK_FLAGS;
					op_val_q  <= ent(1'b1, 1'b1, '0, '0, '0, '0);
					pret_q    <= A_M2;
					state_q   <= P_RMW_A;
				end
				A_M2: begin
					m_idx_q <= idx_q;
					m_len_q <= need_main_q;
					mret_q  <= A_M3;
					state_q <= M_PL0;
				end
				A_M3: begin
					if (need_main_q < avail_q) begin
						// Split off the trailing remainder.
						aux_q     <= idx_q + need_main_q;
						op_addr_q <= AW'(idx_q + need_main_q);
						op_mask_q <= MK_FRESH;
						op_val_q  <= ent(1'b1, 1'b0, ffba_pkg::NONE_IDX, ffba_pkg::NONE_IDX, '0, '0);
						pret_q    <= A_M4;
						state_q   <= P_RMW_A;
					end else begin
						state_q <= A_FIN;
					end
				end
				A_M4: begin
					m_idx_q <= aux_q;
					m_len_q <= avail_q - need_main_q;
					mret_q  <= A_M5;
					state_q <= M_PL0;
				end
				A_M5: begin
					m_idx_q <= aux_q;
					mret_q  <= A_FIN;
					state_q <= M_LI0;
				end
				A_FIN: begin
					used_q <= used_add;
					if (used_add > peak_q) begin
						peak_q <= used_add;
					end
					res_gr_q <= gr_q;
					res_st_q <= ffba_pkg::ST_DONE;
					state_q  <= DONE;
				end
				// Free: validate the run, then merge with free neighbors.
				F0: begin
					if (off_q == '0 || f_idx >= ffba_pkg::NONE_IDX) begin
						res_st_q <= ffba_pkg::ST_IGNORE;
						state_q  <= DONE;
					end else begin
						idx_q     <= f_idx;
						op_addr_q <= f_idx[AW-1:0];
						pret_q    <= F1;
						state_q   <= P_RD;
					end
				end
				F1: begin
					if (!rd_q.head || !rd_q.used) begin
						res_st_q <= ffba_pkg::ST_IGNORE;
						state_q  <= DONE;
					end else begin
						len_q <= rd_q.len;
						if (used_q >= {rd_q.len, {ffba_pkg::BLK_SH{1'b0}}}) begin
							used_q <= used_q - {rd_q.len, {ffba_pkg::BLK_SH{1'b0}}};
						end else begin
							used_q <= '0;
						end
						if (rd_q.back_len != '0 && rd_q.back_len <= idx_q) begin
							aux_q     <= idx_q - rd_q.back_len;
							op_addr_q <= AW'(idx_q - rd_q.back_len);
							pret_q    <= F2;
							state_q   <= P_RD;
						end else begin
							state_q <= F4;
						end
					end
				end
				F2: begin
					if (rd_q.head && !rd_q.used) begin
						m_idx_q <= aux_q;
						m_len_q <= rd_q.len + len_q;
						len_q   <= rd_q.len + len_q;
						mret_q  <= F2B;
						state_q <= M_PL0;
					end else begin
						state_q <= F4;
					end
				end
				F2B: begin
					m_idx_q <= aux_q;
					mret_q  <= F2C;
					state_q <= M_LR0;
				end
				F2C: begin
					op_addr_q <= idx_q[AW-1:0];
					op_mask_q <= MK_FLAGS;
					op_val_q  <= ent(1'b0, 1'b0, '0, '0, '0, '0);
					pret_q    <= F2D;
					state_q   <= P_RMW_A;
				end
				F2D: begin
					idx_q   <= aux_q;
					state_q <= F4;
				end
				F4: begin
					if (f_nx < (IW + 1)'(ffba_pkg::NUM_BLOCKS)) begin
						aux_q     <= f_nx[IW-1:0];
						op_addr_q <= f_nx[AW-1:0];
						pret_q    <= F5;
						state_q   <= P_RD;
					end else begin
						state_q <= F7;
					end
				end
				F5: begin
					if (rd_q.head && !rd_q.used) begin
						m_idx_q <= idx_q;
						m_len_q <= len_q + rd_q.len;
						len_q   <= len_q + rd_q.len;
						mret_q  <= F6;
						state_q <= M_PL0;
					end else begin
						state_q <= F7;
					end
				end
				F6: begin
					m_idx_q <= aux_q;
					mret_q  <= F6B;
					state_q <= M_LR0;
				end
				F6B: begin
					op_addr_q <= aux_q[AW-1:0];
					op_mask_q <= MK_HEAD;
					op_val_q  <= ent(1'b0, 1'b0, '0, '0, '0, '0);
					pret_q    <= F7;
					state_q   <= P_RMW_A;
				end
				F7: begin
					op_addr_q <= idx_q[AW-1:0];
					op_mask_q <= MK_USED;
					op_val_q  <= ent(1'b0, 1'b0, '0, '0, '0, '0);
					pret_q    <= F8;
					state_q   <= P_RMW_A;
				end
				F8: begin
					m_idx_q <= idx_q;
					mret_q  <= F9;
					state_q <= M_LR0;
				end
				F9: begin
					m_idx_q  <= idx_q;
					mret_q   <= DONE;
					res_st_q <= ffba_pkg::ST_DONE;
					state_q  <= M_LI0;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// One request in flight: after a transfer in, input stays closed.
	`FFBA_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	// Peak never falls below the live byte count.
	`FFBA_ASSERT_NOW(a_peak_ge_used, clk, arst_n, 1'b1, peak_q >= used_q, "peak below used")
	// Results appear only out of the completion step.
	`FFBA_ASSERT_NOW(a_result_src, clk, arst_n, $rose(m_tvalid), $past(state_q == DONE), "result without completion")
	// RAM port does one thing per cycle.
	`FFBA_ASSERT_NOW(a_ram_port, clk, arst_n, mem_we, !mem_re, "RAM read and write together")

endmodule

`default_nettype wire

/* tb/ffba_checker.sv */
// Checker for the first-fit block allocator: watches both stream channels,
// predicts every result and compares it. Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_checker (
	input  wire logic        clk,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [15:0] granted;
		logic [1:0]  status;
		logic [16:0] used;
		logic [16:0] peak;
	} grant_t;

	int unsigned pool_len [ffba_pkg::NUM_BLOCKS];
	int unsigned pool_before [ffba_pkg::NUM_BLOCKS];
	int unsigned link_next [ffba_pkg::NUM_BLOCKS];
	int unsigned link_prev [ffba_pkg::NUM_BLOCKS];
	bit          blk_used [ffba_pkg::NUM_BLOCKS];
	bit          blk_head [ffba_pkg::NUM_BLOCKS];
	int unsigned free_head, free_tail, bytes_held, bytes_peak;
	grant_t      grant_q [$];

	function automatic void set_len(int unsigned i, int unsigned n);
		if (i >= ffba_pkg::NUM_BLOCKS) return;
		pool_len[i] = n;
		if (i + n < ffba_pkg::NUM_BLOCKS) pool_before[i + n] = n;
	endfunction

	function automatic void unlink(int unsigned i);
		int unsigned nx, pv;
		if (i >= ffba_pkg::NUM_BLOCKS) return;
		nx = link_next[i];
		pv = link_prev[i];
		if (nx < ffba_pkg::NUM_BLOCKS) link_prev[nx] = pv;
		if (pv < ffba_pkg::NUM_BLOCKS) link_next[pv] = nx;
		if (free_head == i) free_head = nx;
		if (free_tail == i) free_tail = pv;
		link_next[i] = ffba_pkg::NUM_BLOCKS;
		link_prev[i] = ffba_pkg::NUM_BLOCKS;
	endfunction

	function automatic void relink(int unsigned i);
		if (i >= ffba_pkg::NUM_BLOCKS) return;
		link_next[i] = ffba_pkg::NUM_BLOCKS;
		link_prev[i] = ffba_pkg::NUM_BLOCKS;
		if (free_head >= ffba_pkg::NUM_BLOCKS || free_tail >= ffba_pkg::NUM_BLOCKS) begin
			free_head = i;
			free_tail = i;
		end else if (pool_len[i] > ffba_pkg::NUM_BLOCKS / 4) begin
			link_prev[free_head] = i;
			link_next[i] = free_head;
			free_head = i;
		end else begin
			link_next[free_tail] = i;
			link_prev[i] = free_tail;
			free_tail = i;
		end
	endfunction

	function automatic void open_run(int unsigned i);
		if (i >= ffba_pkg::NUM_BLOCKS) return;
		link_next[i] = ffba_pkg::NUM_BLOCKS;
		link_prev[i] = ffba_pkg::NUM_BLOCKS;
		blk_used[i] = 0;
		blk_head[i] = 1;
	endfunction

	function automatic bit try_alloc(longint unsigned sz, int unsigned lg,
			output int unsigned off);
		longint unsigned a, start, pad, need;
		int unsigned i, visits, skip, main_len, avail, rest;
		a = 64'd1 << lg;
		i = free_head;
		visits = 0;
		off = 0;
		while (i < ffba_pkg::NUM_BLOCKS && visits < ffba_pkg::NUM_BLOCKS) begin
			start = 64'(i) * ffba_pkg::BLOCK_BYTES + ffba_pkg::HEADER_BYTES;
			pad = ((start + a - 1) & ~(a - 1)) - start;
			need = (ffba_pkg::HEADER_BYTES + sz + pad + ffba_pkg::BLOCK_BYTES - 1)
				/ ffba_pkg::BLOCK_BYTES;
			visits++;
			if (64'(pool_len[i]) < need) begin
				i = link_next[i];
				continue;
			end
			skip = 32'(pad / ffba_pkg::BLOCK_BYTES);
			main_len = 32'(need) - skip;
			if (skip != 0) begin
				rest = pool_len[i] - skip;
				set_len(i, skip);
				unlink(i);
				relink(i);
				i += skip;
				open_run(i);
				set_len(i, rest);
			end
			avail = pool_len[i];
			unlink(i);
			blk_used[i] = 1;
			blk_head[i] = 1;
			set_len(i, main_len);
			if (main_len < avail) begin
				open_run(i + main_len);
				set_len(i + main_len, avail - main_len);
				relink(i + main_len);
			end
			bytes_held += main_len * ffba_pkg::BLOCK_BYTES;
			if (bytes_held > bytes_peak) bytes_peak = bytes_held;
			off = 32'(start + pad);
			return 1;
		end
		return 0;
	endfunction

	function automatic bit try_release(int unsigned off);
		int unsigned i, nb, pv, n;
		if (off == 0) return 0;
		i = off / ffba_pkg::BLOCK_BYTES;
		if (off % ffba_pkg::BLOCK_BYTES == 0) i -= 1;
		if (i >= ffba_pkg::NUM_BLOCKS || !blk_head[i] || !blk_used[i]) return 0;
		nb = pool_len[i] * ffba_pkg::BLOCK_BYTES;
		bytes_held = (bytes_held >= nb) ? bytes_held - nb : 0;
		if (pool_before[i] != 0 && pool_before[i] <= i) begin
			pv = i - pool_before[i];
			if (blk_head[pv] && !blk_used[pv]) begin
				set_len(pv, pool_len[pv] + pool_len[i]);
				unlink(pv);
				blk_head[i] = 0;
				blk_used[i] = 0;
				i = pv;
			end
		end
		n = i + pool_len[i];
		if (n < ffba_pkg::NUM_BLOCKS && blk_head[n] && !blk_used[n]) begin
			set_len(i, pool_len[i] + pool_len[n]);
			unlink(n);
			blk_head[n] = 0;
		end
		blk_used[i] = 0;
		unlink(i);
		relink(i);
		return 1;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		for (int k = 0; k < ffba_pkg::NUM_BLOCKS; k++) begin
			pool_len[k] = 0; pool_before[k] = 0; link_next[k] = 0;
			link_prev[k] = 0; blk_used[k] = 0; blk_head[k] = 0;
		end
		pool_len[0] = ffba_pkg::NUM_BLOCKS;
		link_next[0] = ffba_pkg::NUM_BLOCKS;
		link_prev[0] = ffba_pkg::NUM_BLOCKS;
		blk_head[0] = 1;
		free_head = 0; free_tail = 0; bytes_held = 0; bytes_peak = 0;
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		grant_t g, w;
		int unsigned off;
		bit ok;
		if (s_tvalid && s_tready) begin
			off = 0;
			if (!s_tuser) begin
				ok = try_alloc(64'(s_tdata[16:0]), 32'(s_tdata[20:17]), off);
				g.status = ok ? ffba_pkg::ST_DONE : ffba_pkg::ST_NO_FIT;
			end else begin
				ok = try_release(32'(s_tdata[36:21]));
				g.status = ok ? ffba_pkg::ST_DONE : ffba_pkg::ST_IGNORE;
			end
			g.granted = off[15:0];
			g.used = bytes_held[16:0];
			g.peak = bytes_peak[16:0];
			grant_q.push_back(g);
		end
		if (m_tvalid && m_tready) begin
			if (grant_q.size() == 0) begin
				report("unexpected result", 32'(m_tdata[15:0]), 32'd0);
			end else begin
				w = grant_q.pop_front();
				if (m_tdata[15:0] !== w.granted)
					report("granted_offset", 32'(m_tdata[15:0]), 32'(w.granted));
				if (m_tuser !== w.status)
					report("status", 32'(m_tuser), 32'(w.status));
				if (m_tdata[32:16] !== w.used)
					report("used_bytes", 32'(m_tdata[32:16]), 32'(w.used));
				if (m_tdata[49:33] !== w.peak)
					report("peak_bytes", 32'(m_tdata[49:33]), 32'(w.peak));
			end
		end
		pending <= grant_q.size();
	end
endmodule

/* tb/tb_first_fit_block_allocator_core.sv */
// Top of the allocator testbench: clock, reset, allocate/free stimulus and
// verdict. Depends on ffba_pkg, ffba_checker and the allocator core.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_core;

	localparam int STALL_LIMIT = 20000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [39:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count, pending;
	int          src_idle_pct, sink_stall_pct, quiet_cycles;
	logic [15:0] live_offs [$];

	first_fit_block_allocator_core u_dut (.*);

	ffba_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: end the run when nothing transfers for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("first_fit_block_allocator_core test failed");
			$finish;
		end
	end

	// Receiver: stall at random at the falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Remember granted offsets so that frees hit live runs.
	always @(posedge clk)
		if (m_tvalid && m_tready && m_tuser == ffba_pkg::ST_DONE && m_tdata[15:0] != 16'd0)
			live_offs.push_back(m_tdata[15:0]);

	// Drive one item from a falling edge; return at the falling edge after its
	// transfer with tvalid still high, so the next call sets it only once.
	task automatic send(logic kind, logic [16:0] req, logic [3:0] lg, logic [15:0] off);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b0, off, lg, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_free_live();
		int k;
		logic [15:0] o;
		if (live_offs.size() == 0) begin
			send(1'b1, 17'($urandom), 4'($urandom), 16'($urandom));
		end else begin
			k = $urandom_range(live_offs.size() - 1);
			o = live_offs[k];
			live_offs.delete(k);
			send(1'b1, 17'($urandom), 4'($urandom), o);
		end
	endtask

	task automatic send_random();
		int r;
		logic [16:0] sz;
		r = $urandom_range(99);
		case ($urandom_range(3))
			0: sz = 17'($urandom_range(64));
			1: sz = 17'($urandom_range(1024));
			2: sz = 17'($urandom_range(8192));
			default: sz = 17'($urandom_range(65536));
		endcase
		if (r < 50) send(1'b0, sz, 4'($urandom_range(15)), 16'($urandom));
		else if (r < 88) send_free_live();
		else if (r < 94) send(1'b1, 17'($urandom), 4'($urandom), 16'($urandom));
		else send(1'b1, 17'($urandom), 4'($urandom),
			16'(live_offs.size() ? live_offs[0] + 1 : 0));
	endtask

	initial begin
		arst_n = 1'b0; s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0; m_tready = 1'b0;
		src_idle_pct = 0; sink_stall_pct = 0; quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed: extremes, alignment, null, bad and double free.
		send(1'b0, 17'd0, 4'd0, 16'd0);
		send(1'b0, 17'd65536, 4'd0, 16'd0);
		send(1'b0, 17'd1, 4'd12, 16'd0);
		send(1'b0, 17'd100, 4'd15, 16'd0);
		send(1'b0, 17'd48, 4'd13, 16'd0);
		send(1'b0, 17'd200, 4'd6, 16'd0);
		send(1'b1, 17'd0, 4'd0, 16'd0);
		send(1'b1, 17'd0, 4'd0, 16'hFFFF);
		send(1'b1, 17'd0, 4'd0, 16'd17);
		send(1'b1, 17'h1FFFF, 4'hF, 16'd16);
		send(1'b1, 17'd0, 4'd0, 16'd16);
		send(1'b0, 17'd65000, 4'd0, 16'd0);
		send_free_live();
		send_free_live();
		send_free_live();
		send_free_live();
		send(1'b0, 17'd131071, 4'd15, 16'd0);
		// Random phases with varying idle and stall pressure.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
				default: begin src_idle_pct = 27; sink_stall_pct = 27; end
			endcase
			for (int n = 0; n < 435; n++) send_random();
		end
		s_tvalid <= 1'b0;
		sink_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("first_fit_block_allocator_core test passed");
		else
			$display("first_fit_block_allocator_core test failed");
		$finish;
	end
endmodule
